### src/eht_pkg.sv
// Shared types and constants of the extended header option parser.
package eht_pkg;

   localparam int CFG_WIDTH = 8;
   localparam int COUNT_WIDTH = 16;

   localparam logic [7:0] FORMAT_MIN_LEN = 8'd2;
   localparam logic [1:0] VALUE_CAPTURE = 2'd2;

   typedef enum logic [1:0] {
      CSR_TYPE_MASK = 2'd0,
      CSR_CRITICAL_MASK = 2'd1,
      CSR_MAINT_GET_CODE = 2'd2,
      CSR_FORMAT_INFO_CODE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_LEN = 2'd1,
      PH_VALUE = 2'd2,
      PH_HALT = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_MAINT = 2'd1,
      KIND_FORMAT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_SUCCESS = 2'd0,
      STATUS_OPTION_ERROR = 2'd1,
      STATUS_DROP = 2'd2
   } status_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] type_mask;
      logic [CFG_WIDTH-1:0] critical_mask;
      logic [CFG_WIDTH-1:0] maint_get_code;
      logic [CFG_WIDTH-1:0] format_info_code;
   } cfg_type;

   typedef struct packed {
      status_type status;
      logic maint_requested;
      logic format_seen;
      logic [7:0] format_first;
      logic [7:0] format_second;
      logic [COUNT_WIDTH-1:0] header_size;
   } result_type;

endpackage

### src/eht_csr.sv
// Configuration registers of the extended header option parser.
module eht_csr (
   input logic clock,
   input logic reset,
   input logic csr_write_enable,
   input logic [1:0] csr_index,
   input logic [eht_pkg::CFG_WIDTH-1:0] csr_write_data,
   output eht_pkg::cfg_type cfg
);
   import eht_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_TYPE_MASK: cfg_in.type_mask = csr_write_data;
            CSR_CRITICAL_MASK: cfg_in.critical_mask = csr_write_data;
            CSR_MAINT_GET_CODE: cfg_in.maint_get_code = csr_write_data;
            CSR_FORMAT_INFO_CODE: cfg_in.format_info_code = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.type_mask <= 8'd127;
         cfg_ff.critical_mask <= 8'd128;
         cfg_ff.maint_get_code <= 8'd2;
         cfg_ff.format_info_code <= 8'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/eht_core.sv
// Frame state and per-byte option parsing of the extended header parser.
module eht_core (
   input logic clock,
   input logic reset,
   input logic fire,
   input logic [7:0] data_byte,
   input logic last_byte,
   input eht_pkg::cfg_type cfg,
   output eht_pkg::result_type result
);
   import eht_pkg::*;

   phase_type phase_ff, phase_in, phase_p;
   kind_type kind_ff, kind_in, kind_p;
   logic [7:0] remaining_ff, remaining_in, remaining_p;
   logic [1:0] index_ff, index_in, index_p;
   logic error_ff, error_in, error_p;
   logic maint_ff, maint_in, maint_p;
   logic format_ff, format_in, format_p;
   logic [7:0] first_ff, first_in, first_p;
   logic [7:0] second_ff, second_in, second_p;
   logic [COUNT_WIDTH-1:0] count_ff, count_in, count_p;
   logic [7:0] code;

   always_comb begin
      code = data_byte & cfg.type_mask;
      phase_p = phase_ff;
      kind_p = kind_ff;
      remaining_p = remaining_ff;
      index_p = index_ff;
      error_p = error_ff;
      maint_p = maint_ff;
      format_p = format_ff;
      first_p = first_ff;
      second_p = second_ff;
      count_p = (count_ff == '1) ? count_ff : count_ff + 1'b1;
      unique case (phase_ff)
         PH_TYPE: begin
            phase_p = PH_LEN;
            if (code == cfg.maint_get_code) begin
               kind_p = KIND_MAINT;
               maint_p = 1'b1;
            end else if (code == cfg.format_info_code) begin
               kind_p = KIND_FORMAT;
            end else begin
               kind_p = KIND_OTHER;
               if ((data_byte & cfg.critical_mask) != 8'd0) begin
                  error_p = 1'b1;
                  phase_p = PH_HALT;
               end
            end
         end
         PH_LEN: begin
            if (kind_ff == KIND_FORMAT && data_byte < FORMAT_MIN_LEN) begin
               error_p = 1'b1;
               phase_p = PH_HALT;
            end else begin
               remaining_p = data_byte;
               index_p = 2'd0;
               phase_p = (data_byte == 8'd0) ? PH_TYPE : PH_VALUE;
            end
         end
         PH_VALUE: begin
            if (kind_ff == KIND_FORMAT && index_ff < VALUE_CAPTURE) begin
               if (index_ff == 2'd0) begin
                  first_p = data_byte;
               end else begin
                  second_p = data_byte;
                  format_p = 1'b1;
               end
            end
            if (index_ff < VALUE_CAPTURE) begin
               index_p = index_ff + 2'd1;
            end
            remaining_p = remaining_ff - 8'd1;
            if (remaining_ff == 8'd1) begin
               phase_p = PH_TYPE;
            end
         end
         PH_HALT: begin
            phase_p = PH_HALT;
         end
         default: phase_p = PH_HALT;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         phase_in = last_byte ? PH_TYPE : phase_p;
      end
   end

   always_comb begin
      kind_in = kind_ff;
      remaining_in = remaining_ff;
      index_in = index_ff;
      error_in = error_ff;
      maint_in = maint_ff;
      format_in = format_ff;
      first_in = first_ff;
      second_in = second_ff;
      count_in = count_ff;
      if (fire && last_byte) begin
         kind_in = KIND_OTHER;
         remaining_in = 8'd0;
         index_in = 2'd0;
         error_in = 1'b0;
         maint_in = 1'b0;
         format_in = 1'b0;
         first_in = 8'd0;
         second_in = 8'd0;
         count_in = '0;
      end else if (fire) begin
         kind_in = kind_p;
         remaining_in = remaining_p;
         index_in = index_p;
         error_in = error_p;
         maint_in = maint_p;
         format_in = format_p;
         first_in = first_p;
         second_in = second_p;
         count_in = count_p;
      end
   end

   always_comb begin
      if (error_p) begin
         result.status = STATUS_OPTION_ERROR;
      end else if (phase_p != PH_TYPE) begin
         result.status = STATUS_DROP;
      end else begin
         result.status = STATUS_SUCCESS;
      end
      result.maint_requested = maint_p;
      result.format_seen = format_p;
      result.format_first = first_p;
      result.format_second = second_p;
      result.header_size = count_p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         kind_ff <= KIND_OTHER;
         remaining_ff <= 8'd0;
         index_ff <= 2'd0;
         error_ff <= 1'b0;
         maint_ff <= 1'b0;
         format_ff <= 1'b0;
         first_ff <= 8'd0;
         second_ff <= 8'd0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         kind_ff <= kind_in;
         remaining_ff <= remaining_in;
         index_ff <= index_in;
         error_ff <= error_in;
         maint_ff <= maint_in;
         format_ff <= format_in;
         first_ff <= first_in;
         second_ff <= second_in;
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_halt_iff_error: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT) == error_ff)
      else $error("Parser halt state and error flag disagree.");

   a_value_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_VALUE |-> remaining_ff != 8'd0)
      else $error("Value phase entered with no bytes remaining.");

   a_format_needs_two: assert property (@(posedge clock) disable iff (reset)
      format_ff && fire && !last_byte |=> format_ff && count_ff >= 16'd4)
      else $error("Format option captured before enough bytes arrived.");
`endif

endmodule

### src/ext_header_tlv_parser.sv
// Top level of the extended header option parser.
// The result item is registered at the edge that takes the last byte out of the input
// register. Throughput: one header byte per cycle; only a last byte waits, while an
// earlier result item is still stalled on the output. Reset is synchronous: it empties
// both pipeline registers, clears the frame state and restores the configuration
// register defaults.
module ext_header_tlv_parser (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [7:0] req_data_byte,
   input logic req_last_byte,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [1:0] rsp_status,
   output logic rsp_maint_requested,
   output logic rsp_format_seen,
   output logic [7:0] rsp_format_first,
   output logic [7:0] rsp_format_second,
   output logic [eht_pkg::COUNT_WIDTH-1:0] rsp_header_size,
   input logic csr_write_enable,
   input logic [1:0] csr_index,
   input logic [eht_pkg::CFG_WIDTH-1:0] csr_write_data
);
   import eht_pkg::*;

   cfg_type cfg;
   result_type result;
   result_type result_ff;
   logic in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic in_last_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic fire;

   eht_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .cfg(cfg)
   );

   eht_core u_core (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .data_byte(in_byte_ff),
      .last_byte(in_last_ff),
      .cfg(cfg),
      .result(result)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign fire = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (fire && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (fire && in_last_ff) begin
         result_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = result_ff.status;
   assign rsp_maint_requested = result_ff.maint_requested;
   assign rsp_format_seen = result_ff.format_seen;
   assign rsp_format_first = result_ff.format_first;
   assign rsp_format_second = result_ff.format_second;
   assign rsp_header_size = result_ff.header_size;

`ifndef NO_ASSERTIONS
   a_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_header_size != '0)
      else $error("Result item reports an empty header.");

   a_last_waits: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_ready |=> in_valid_ff && in_last_ff)
      else $error("Last byte left the input register while the result was stalled.");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      fire && in_last_ff |=> rsp_valid_ff)
      else $error("Last byte consumed without a result item.");
`endif

endmodule
